>>> rtl/core/map_target_frame_encoder_assert.svh
// Assertion macros for the checker file.
`ifndef MAP_TARGET_FRAME_ENCODER_ASSERT_SVH
`define MAP_TARGET_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define MTFE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, masked while reset is high.
`define MTFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that is checked through reset as well.
`define MTFE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/core/mtfe_pkg.sv
`timescale 1ns / 1ps

package mtfe_pkg;

   // Frame layout
   localparam int FRAME_LEN = 23;
   localparam int IDX_W     = $clog2(FRAME_LEN);
   localparam int BODY_LEN  = FRAME_LEN - 2;

   localparam logic [IDX_W-1:0] IDX_FIRST  = IDX_W'(0);
   localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(FRAME_LEN - 2);
   localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(FRAME_LEN - 1);

   localparam logic [7:0]  SOF_BYTE = 8'hA5;
   localparam logic [15:0] DATA_LEN = 16'd14;
   localparam logic [15:0] CMD_WORD = 16'h0305;

   localparam logic [7:0]  CRC8_SEED  = 8'hFF;
   localparam logic [7:0]  CRC8_POLY  = 8'h8C;
   localparam logic [15:0] CRC16_INIT = 16'hFFFF;
   localparam logic [15:0] CRC16_POLY = 16'h8408;

   typedef struct packed {
      logic [15:0] robot_id;
      logic [31:0] pos_x_bits;
      logic [31:0] pos_y_bits;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } rsp_type;

   // Classified item handed from front to back
   typedef struct packed {
      req_type    report;
      logic [7:0] seq;
      logic [7:0] crc8;
   } desc_type;

   // One byte through the reflected CRC8
   function automatic logic [7:0] crc8_byte(input logic [7:0] c_in, input logic [7:0] d);
      logic [7:0] c;
      c = c_in ^ d;
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // One byte through the reflected CRC16
   function automatic logic [15:0] crc16_byte(input logic [15:0] c_in, input logic [7:0] d);
      logic [15:0] c;
      c = c_in ^ {8'h00, d};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // CRC8 state after the three fixed header bytes
   localparam logic [7:0] CRC8_PRE =
      crc8_byte(crc8_byte(crc8_byte(CRC8_SEED, SOF_BYTE), DATA_LEN[7:0]), DATA_LEN[15:8]);

endpackage

>>> rtl/core/mtfe_front.sv
`timescale 1ns / 1ps

module mtfe_front import mtfe_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   input  logic     q_full,
   output logic     q_push,
   output desc_type q_push_data
);

   logic [7:0] seq_ff;
   logic [7:0] seq_in;

   // Take an item whenever the queue has room
   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   // Tag the item with its sequence number and header CRC
   always_comb begin
      q_push_data.report = req_data;
      q_push_data.seq    = seq_ff;
      q_push_data.crc8   = crc8_byte(CRC8_PRE, seq_ff);
   end

   // Advance the sequence number once per accepted item
   always_comb begin
      seq_in = q_push ? seq_ff + 8'd1 : seq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= 8'd0;
      end else begin
         seq_ff <= seq_in;
      end
   end

endmodule

>>> rtl/core/mtfe_queue.sv
`timescale 1ns / 1ps

module mtfe_queue import mtfe_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output desc_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type            mem [0:DEPTH-1];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != CNT_W'(0));
   assign head_data  = mem[rd_ptr_ff];

   // Wrap pointers and track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/mtfe_back.sv
`timescale 1ns / 1ps

module mtfe_back import mtfe_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     head_valid,
   input  desc_type head_data,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [15:0]      crc_ff, crc_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;
   logic [7:0]       body [0:BODY_LEN-1];
   logic             out_adv;
   logic             emit;
   logic             in_body;

   // Lay out the frame body little-endian
   always_comb begin
      body[0]  = SOF_BYTE;
      body[1]  = DATA_LEN[7:0];
      body[2]  = DATA_LEN[15:8];
      body[3]  = head_data.seq;
      body[4]  = head_data.crc8;
      body[5]  = CMD_WORD[7:0];
      body[6]  = CMD_WORD[15:8];
      body[7]  = head_data.report.robot_id[7:0];
      body[8]  = head_data.report.robot_id[15:8];
      body[9]  = head_data.report.pos_x_bits[7:0];
      body[10] = head_data.report.pos_x_bits[15:8];
      body[11] = head_data.report.pos_x_bits[23:16];
      body[12] = head_data.report.pos_x_bits[31:24];
      body[13] = head_data.report.pos_y_bits[7:0];
      body[14] = head_data.report.pos_y_bits[15:8];
      body[15] = head_data.report.pos_y_bits[23:16];
      body[16] = head_data.report.pos_y_bits[31:24];
      body[17] = 8'h00;
      body[18] = 8'h00;
      body[19] = 8'h00;
      body[20] = 8'h00;
   end

   // Emit one byte whenever the output register is free and a report waits at the queue head
   assign out_adv = !out_valid_ff || rsp_ready;
   assign emit    = head_valid && out_adv;
   assign in_body = (idx_ff < IDX_CRC_LO);
   assign pop     = emit && (idx_ff == IDX_CRC_HI);

   // Pick the byte, fold body bytes into the CRC
   always_comb begin
      out_in = out_ff;
      crc_in = crc_ff;
      case (idx_ff)
         IDX_CRC_LO: begin
            out_in.frame_byte = crc_ff[7:0];
            out_in.frame_end  = 1'b0;
         end
         IDX_CRC_HI: begin
            out_in.frame_byte = crc_ff[15:8];
            out_in.frame_end  = 1'b1;
         end
         default: begin
            out_in.frame_byte = in_body ? body[idx_ff] : 8'h00;
            out_in.frame_end  = 1'b0;
            crc_in = crc16_byte((idx_ff == IDX_FIRST) ? CRC16_INIT : crc_ff,
                                out_in.frame_byte);
         end
      endcase
   end

   // Step the byte index, wrap at frame end
   always_comb begin
      idx_in = idx_ff;
      if (emit) begin
         idx_in = pop ? IDX_FIRST : idx_ff + IDX_W'(1);
      end
   end

   // Hold the output until taken
   always_comb begin
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= IDX_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff <= out_in;
         crc_ff <= crc_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

>>> rtl/core/map_target_frame_encoder.sv
`timescale 1ns / 1ps

// Turns each target report (robot id, raw x and y float bits) into a 23-byte
// serial frame: 0xA5 start byte, length 14, an 8-bit wrapping sequence number,
// CRC8 over the header, command 0x0305, the report fields little-endian, four
// zero bytes and a CRC16 trailer sent low byte first. Bytes leave one per item
// on the rsp channel, the 23rd marked with frame_end. The byte serializer
// sends one byte per cycle unless rsp_ready stalls the output; a queued next
// frame follows with no gap. With the serializer idle, an accepted report is
// written into the report queue and its first byte is then registered into
// the output register. Reports are taken while the report queue (QUEUE_DEPTH
// entries) has room, so the next report can wait while a frame is still going
// out. The sequence number starts at zero after reset.

module map_target_frame_encoder import mtfe_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic     q_full;
   logic     q_push;
   desc_type q_push_data;
   logic     q_pop;
   logic     q_head_valid;
   desc_type q_head_data;

   mtfe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   mtfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head_data)
   );

   mtfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_data  (q_head_data),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

>>> rtl/core/mtfe_checker.sv
`timescale 1ns / 1ps
`include "map_target_frame_encoder_assert.svh"

module mtfe_checker import mtfe_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic rsp_stall;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // Stalled byte stays offered and unchanged
   `MTFE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid)
   `MTFE_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_data))

   // Reset empties the block: nothing shown, queue open
   `MTFE_ASSERT_NEXT_ALWAYS(a_rst_idle, clock, reset, !rsp_valid)
   `MTFE_ASSERT_NEXT_ALWAYS(a_rst_ready, clock, reset, req_ready)

   // A frame end is never two bytes in a row
   `MTFE_ASSERT_NOW(a_end_gap, clock, reset,
      rsp_valid && rsp_data.frame_end && $past(rsp_valid && rsp_ready && !reset),
      !$past(rsp_data.frame_end))

endmodule

bind map_target_frame_encoder mtfe_checker u_mtfe_checker (.*);

>>> dv/map_target_frame_encoder_tb.sv
`timescale 1ns / 1ps

module map_target_frame_encoder_tb;
   import mtfe_pkg::*;

   // Frame layout and checksum constants, kept apart from the design's own
   localparam int          REPORT_BYTES    = 23;
   localparam logic [7:0]  FRAME_START     = 8'hA5;
   localparam logic [15:0] PAYLOAD_LEN     = 16'd14;
   localparam logic [15:0] MAP_CMD         = 16'h0305;
   localparam logic [7:0]  HDR_CRC_SEED    = 8'hFF;
   localparam logic [7:0]  HDR_CRC_POLY    = 8'h8C;
   localparam logic [15:0] FRAME_CRC_SEED  = 16'hFFFF;
   localparam logic [15:0] FRAME_CRC_POLY  = 16'h8408;

   // Run shape
   localparam int RANDOM_REPORTS = 96;
   localparam int STEADY_REPORTS = 35;
   localparam int IDLE_PCT       = 24;
   localparam int STALL_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int MAX_PRINTS     = 30;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type    frame_bytes_due[$];
   logic [7:0] frame_seq;
   bit         steady;
   int         reports_sent;
   int         bytes_checked;
   int         error_count;
   int         quiet_cycles;

   map_target_frame_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Build the 23 frame bytes for one report and queue them in send order
   function automatic void queue_frame(input req_type rpt, input logic [7:0] seq);
      logic [7:0]  fb [REPORT_BYTES];
      logic [7:0]  hdr_crc;
      logic [15:0] frame_crc;
      rsp_type     want;
      int          i;
      int          b;
      for (i = 0; i < REPORT_BYTES; i++) begin
         fb[i] = 8'h00;
      end
      fb[0] = FRAME_START;
      fb[1] = PAYLOAD_LEN[7:0];
      fb[2] = PAYLOAD_LEN[15:8];
      fb[3] = seq;
      // header checksum, reflected, one bit at a time LSB first
      hdr_crc = HDR_CRC_SEED;
      for (i = 0; i < 4; i++) begin
         for (b = 0; b < 8; b++) begin
            if (hdr_crc[0] ^ fb[i][b]) begin
               hdr_crc = (hdr_crc >> 1) ^ HDR_CRC_POLY;
            end else begin
               hdr_crc = hdr_crc >> 1;
            end
         end
      end
      fb[4] = hdr_crc;
      fb[5] = MAP_CMD[7:0];
      fb[6] = MAP_CMD[15:8];
      fb[7] = rpt.robot_id[7:0];
      fb[8] = rpt.robot_id[15:8];
      for (i = 0; i < 4; i++) begin
         fb[9 + i]  = rpt.pos_x_bits[8*i +: 8];
         fb[13 + i] = rpt.pos_y_bits[8*i +: 8];
      end
      // trailer checksum over everything ahead of it
      frame_crc = FRAME_CRC_SEED;
      for (i = 0; i < REPORT_BYTES - 2; i++) begin
         for (b = 0; b < 8; b++) begin
            if (frame_crc[0] ^ fb[i][b]) begin
               frame_crc = (frame_crc >> 1) ^ FRAME_CRC_POLY;
            end else begin
               frame_crc = frame_crc >> 1;
            end
         end
      end
      fb[REPORT_BYTES-2] = frame_crc[7:0];
      fb[REPORT_BYTES-1] = frame_crc[15:8];
      for (i = 0; i < REPORT_BYTES; i++) begin
         want.frame_byte = fb[i];
         want.frame_end  = (i == REPORT_BYTES - 1);
         frame_bytes_due.push_back(want);
      end
   endfunction

   function automatic void report_mismatch(input string field, input logic [7:0] want,
                                           input logic [7:0] got);
      error_count++;
      if (error_count <= MAX_PRINTS) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endfunction

   // Stall the frame byte output at random, except in steady stretches
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // Predict on each accepted report, check each accepted byte, watch for a hang
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         frame_seq    = 8'h00;
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (req_valid && req_ready) begin
            queue_frame(req_data, frame_seq);
            frame_seq    = frame_seq + 8'd1;
            quiet_cycles = 0;
         end
         if (rsp_valid && rsp_ready) begin
            quiet_cycles = 0;
            if (frame_bytes_due.size() == 0) begin
               error_count++;
               if (error_count <= MAX_PRINTS) begin
                  $display("%0t: unexpected frame byte, expected none, actual %h end %b",
                           $time, rsp_data.frame_byte, rsp_data.frame_end);
               end
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_data.frame_byte !== want.frame_byte) begin
                  report_mismatch("frame_byte", want.frame_byte, rsp_data.frame_byte);
               end
               if (rsp_data.frame_end !== want.frame_end) begin
                  report_mismatch("frame_end", {7'd0, want.frame_end},
                                  {7'd0, rsp_data.frame_end});
               end
               bytes_checked++;
            end
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("map_target_frame_encoder_tb: errors");
            $finish;
         end
      end
   end

   // Offer one report, with a random gap first unless in a steady stretch
   task automatic send_report(input req_type rpt);
      int gap;
      gap = 0;
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            gap++;
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rpt;
      do @(posedge clock); while (!req_ready);
      reports_sent++;
   endtask

   function automatic logic [31:0] pick_float_bits();
      logic [31:0] odd_values [6];
      odd_values = '{32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'h80000000,
                     32'h00000001, 32'h7F7FFFFF};
      if ($urandom_range(7) == 0) begin
         return odd_values[$urandom_range(5)];
      end
      return $urandom;
   endfunction

   function automatic req_type random_report();
      req_type rpt;
      rpt.robot_id   = 16'($urandom);
      rpt.pos_x_bits = pick_float_bits();
      rpt.pos_y_bits = pick_float_bits();
      return rpt;
   endfunction

   // Field extremes and odd float patterns: infinities, NaN, negative zero, denormal
   task automatic test_directed_reports();
      req_type corners [10];
      corners = '{
         '{16'h0000, 32'h00000000, 32'h00000000},
         '{16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
         '{16'h0001, 32'h7F800000, 32'hFF800000},
         '{16'h8000, 32'h7FC00000, 32'hFFC00001},
         '{16'hAAAA, 32'h80000000, 32'h00000001},
         '{16'h5555, 32'hAAAAAAAA, 32'h55555555},
         '{16'h00FF, 32'h3F800000, 32'hBF800000},
         '{16'hFF00, 32'h7F7FFFFF, 32'h00800000},
         '{16'h1234, 32'h12345678, 32'h9ABCDEF0},
         '{16'hFFFF, 32'h00000000, 32'hFFFFFFFF}
      };
      steady = 1'b0;
      foreach (corners[i]) begin
         send_report(corners[i]);
      end
      // the first four patterns again, back to back with no stalls
      steady = 1'b1;
      for (int i = 0; i < 4; i++) begin
         send_report(corners[i]);
      end
   endtask

   // Random reports: a steady stretch first, then random gaps and stalls
   task automatic test_random_reports();
      for (int i = 0; i < RANDOM_REPORTS; i++) begin
         steady = (i < STEADY_REPORTS);
         send_report(random_report());
      end
   endtask

   initial begin
      steady        = 1'b0;
      reports_sent  = 0;
      bytes_checked = 0;
      error_count   = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_reports();
      test_random_reports();
      req_valid <= 1'b0;
      // drain, then give any stray byte time to show up
      steady = 1'b0;
      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d reports (corner floats, random fields, gaps and stalls),",
               reports_sent);
      $display("checked %0d frame bytes against the predicted frames.", bytes_checked);
      if (error_count == 0) begin
         $display("map_target_frame_encoder_tb: clean");
      end else begin
         $display("map_target_frame_encoder_tb: errors");
      end
      $finish;
   end

endmodule
